>>> sv/eauv_pkg.sv
package eauv_pkg;

    localparam int ANGLE_BITS = 12;
    localparam int ST_W       = 12;
    localparam int PROD_W     = ANGLE_BITS + 20;
    localparam int CNT_W      = $clog2(PROD_W);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;
    localparam int IN_W       = 48;
    localparam int OUT_W      = 176;

    localparam logic [19:0] US_PER_S = 20'd1000000;

    typedef struct packed {
        logic                  valid_res;
        logic [31:0]           sample_seq;
        logic [31:0]           stamp_out;
        logic [ST_W-1:0]       single_turn_count;
        logic signed [31:0]    full_angle_count;
        logic [31:0]           failure_total;
        logic [ANGLE_BITS-1:0] mag;
        logic                  neg;
        logic [31:0]           elapsed;
        logic                  need_div;
    } t_job;

    typedef struct packed {
        logic                  valid_res;
        logic [31:0]           sample_seq;
        logic [31:0]           stamp_out;
        logic [ST_W-1:0]       single_turn_count;
        logic signed [31:0]    full_angle_count;
        logic signed [31:0]    speed_counts_per_s;
        logic [31:0]           failure_total;
    } t_res;

    typedef struct packed {
        logic push;
        logic full;
    } t_qctl;

endpackage

>>> sv/eauv_front.sv
module eauv_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [15:0]              i_angle_word,
    input  logic [31:0]              i_time_us,
    input  logic                     i_read_failed,
    input  logic                     i_full,
    output logic                     o_push,
    output eauv_pkg::t_job           o_job
);

    logic                            r_awaiting_first;
    logic [eauv_pkg::ANGLE_BITS-1:0] r_last_count;
    logic [31:0]                     r_last_stamp;
    logic [31:0]                     r_turn_acc;
    logic [31:0]                     r_seq;
    logic [31:0]                     r_fail;

    logic [eauv_pkg::ANGLE_BITS-1:0] count;
    logic [eauv_pkg::ANGLE_BITS-1:0] diff;
    logic [31:0]                     elapsed;
    logic [31:0]                     n_turn_acc;
    logic [31:0]                     n_seq;
    logic [31:0]                     n_fail;
    logic                            accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    assign count   = i_angle_word[eauv_pkg::ANGLE_BITS-1:0];
    // shortest step is the modular difference read as two's complement
    assign diff    = count - r_last_count;
    assign elapsed = i_time_us - r_last_stamp;
    assign n_seq   = r_seq + 32'd1;
    assign n_fail  = r_fail + 32'd1;

    always_comb begin
        if (r_awaiting_first) begin
            n_turn_acc = 32'(count);
        end else begin
            n_turn_acc = r_turn_acc + 32'($signed(diff));
        end
    end

    always_comb begin
        o_job = '0;
        if (i_read_failed) begin
            o_job.failure_total = n_fail;
        end else begin
            o_job.valid_res         = 1'b1;
            o_job.sample_seq        = n_seq;
            o_job.stamp_out         = i_time_us;
            o_job.single_turn_count = eauv_pkg::ST_W'(count);
            o_job.full_angle_count  = n_turn_acc;
            o_job.failure_total     = r_fail;
            o_job.neg               = diff[eauv_pkg::ANGLE_BITS-1];
            o_job.mag               = diff[eauv_pkg::ANGLE_BITS-1] ? (~diff + 1'b1) : diff;
            o_job.elapsed           = elapsed;
            o_job.need_div          = !r_awaiting_first && (elapsed != 32'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting_first <= 1'b1;
            r_last_count     <= '0;
            r_last_stamp     <= '0;
            r_turn_acc       <= '0;
            r_seq            <= '0;
            r_fail           <= '0;
        end else if (accept) begin
            if (i_read_failed) begin
                r_fail <= n_fail;
            end else begin
                r_awaiting_first <= 1'b0;
                r_last_count     <= count;
                r_last_stamp     <= i_time_us;
                r_turn_acc       <= n_turn_acc;
                r_seq            <= n_seq;
            end
        end
    end

endmodule

>>> sv/eauv_fifo.sv
module eauv_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  eauv_pkg::t_qctl i_ctl,
    input  eauv_pkg::t_job  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output eauv_pkg::t_job  o_data
);

    eauv_pkg::t_job              r_mem [eauv_pkg::QDEPTH];
    logic [eauv_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [eauv_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [eauv_pkg::QCNT_W-1:0] r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_count == eauv_pkg::QCNT_W'(eauv_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_ctl.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= eauv_pkg::QCNT_W'(eauv_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue push lost");

    a_pop_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop |=> (r_rd_ptr == $past(r_rd_ptr) + 1'b1))
        else $error("queue read pointer did not advance");

endmodule

>>> sv/eauv_back.sv
module eauv_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  eauv_pkg::t_job i_q_data,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output eauv_pkg::t_res o_res
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_back_state;

    t_back_state                r_state;
    t_back_state                n_state;
    eauv_pkg::t_job             r_job;
    logic [eauv_pkg::PROD_W-1:0] r_quo;
    logic [31:0]                r_rem;
    logic [31:0]                r_div;
    logic [eauv_pkg::CNT_W-1:0] r_cnt;
    logic                       r_out_valid;
    eauv_pkg::t_res             r_out;

    logic [32:0]                rem_sh;
    logic                       rem_ge;
    logic [31:0]                n_rem;
    logic [31:0]                quo32;
    logic                       load_out;
    eauv_pkg::t_res             res;

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign load_out = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh = {r_rem, r_quo[eauv_pkg::PROD_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_div};
    assign n_rem  = rem_ge ? 32'(rem_sh - {1'b0, r_div}) : rem_sh[31:0];
    assign quo32  = 32'(r_quo);

    always_comb begin
        res.valid_res          = r_job.valid_res;
        res.sample_seq         = r_job.sample_seq;
        res.stamp_out          = r_job.stamp_out;
        res.single_turn_count  = r_job.single_turn_count;
        res.full_angle_count   = r_job.full_angle_count;
        res.failure_total      = r_job.failure_total;
        if (!r_job.need_div) begin
            res.speed_counts_per_s = '0;
        end else if (r_job.neg) begin
            res.speed_counts_per_s = ~quo32 + 32'd1;
        end else begin
            res.speed_counts_per_s = quo32;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) n_state = i_q_data.need_div ? S_MUL : S_DONE;
            end
            S_MUL:  n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == '0) n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_data;
        end
        if (r_state == S_MUL) begin
            r_quo <= eauv_pkg::PROD_W'(r_job.mag) * eauv_pkg::PROD_W'(eauv_pkg::US_PER_S);
            r_rem <= '0;
            r_div <= r_job.elapsed;
            r_cnt <= eauv_pkg::CNT_W'(eauv_pkg::PROD_W - 1);
        end else if (r_state == S_DIV) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[eauv_pkg::PROD_W-2:0], rem_ge};
            r_cnt <= r_cnt - 1'b1;
        end
        if (load_out) begin
            r_out <= res;
        end
    end

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_DONE))
        else $error("divider did not finish after last step");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

    a_pop_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_MUL || r_state == S_DONE))
        else $error("popped job not started");

endmodule

>>> sv/encoder_angle_unwrap_velocity.sv
// A beat that needs a speed quotient passes queue pop, multiply, 32 divider steps
// and result load before it reaches m_axis; other beats pass queue pop and result load.
// The back end takes no new beat from the queue until the last result is loaded, and
// speed beats are bound by the bit-serial divider that retires one quotient bit per cycle.
// A two-entry queue and an output register let s_axis accept while results wait.
// Reset (i_rst_n low, synchronous) clears counters, history, queue and output valid.
module encoder_angle_unwrap_velocity (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] angle_word, [47:16] time_us
    input  logic [eauv_pkg::IN_W-1:0]     s_axis_tdata,
    // [0] read_failed
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] sample_seq, [63:32] stamp_out, [75:64] single_turn_count,
    // [107:76] full_angle_count, [139:108] speed_counts_per_s,
    // [171:140] failure_total, [175:172] zero
    output logic [eauv_pkg::OUT_W-1:0]    m_axis_tdata,
    // [0] valid_res
    output logic                          m_axis_tuser
);

    eauv_pkg::t_job  push_job;
    eauv_pkg::t_job  pop_job;
    eauv_pkg::t_qctl qctl;
    eauv_pkg::t_res  res;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic            push;

    assign qctl.push = push;
    assign qctl.full = q_full;

    eauv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_angle_word  (s_axis_tdata[15:0]),
        .i_time_us     (s_axis_tdata[47:16]),
        .i_read_failed (s_axis_tuser),
        .i_full        (qctl.full),
        .o_push        (push),
        .o_job         (push_job)
    );

    eauv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (qctl),
        .i_data  (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (pop_job)
    );

    eauv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (pop_job),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (res)
    );

    assign m_axis_tuser = res.valid_res;
    assign m_axis_tdata = {4'b0000,
                           res.failure_total,
                           res.speed_counts_per_s,
                           res.full_angle_count,
                           res.single_turn_count,
                           res.stamp_out,
                           res.sample_seq};

endmodule
